FILE: hdl/atp_pkg.sv
// Shared constants, types and arctangent table for the phase lookup pipeline.
package atp_pkg;

	localparam int SampleWidth = 32;
	localparam int PhaseWidth  = 12;
	localparam int HalfTurn    = 1608;
	localparam int QuarterTurn = 804;
	localparam int FracShift   = 9;
	localparam int QuotBits    = FracShift + 1;
	localparam int RomDepth    = 1 << FracShift;
	localparam int AddrWidth   = FracShift;
	localparam int TabWidth    = 9;
	localparam int FrontStages = 2;
	localparam int FoldStages  = 2;
	localparam int PipeDepth   = FrontStages + QuotBits + FoldStages;

	localparam logic [SampleWidth-1:0] BigMax = SampleWidth'(4194304);
	localparam logic [AddrWidth-1:0]   AddrMax = AddrWidth'(511);

	localparam real Pi = 3.14159265358979323846;

	typedef enum logic [2:0] {
		OctQ1Lo = 3'd0,
		OctQ1Hi = 3'd1,
		OctQ4Lo = 3'd2,
		OctQ4Hi = 3'd3,
		OctQ2Lo = 3'd4,
		OctQ2Hi = 3'd5,
		OctQ3Lo = 3'd6,
		OctQ3Hi = 3'd7
	} octant_t;

	typedef struct packed {
		logic [SampleWidth-1:0] rem;
		logic [SampleWidth-1:0] dsh;
		logic [QuotBits-1:0]    quot;
		octant_t                oct;
		logic                   zero;
	} div_word_t;

	typedef logic [TabWidth-1:0] rom_t [RomDepth];

	function automatic rom_t atan_rom_build();
		rom_t rom;
		real  r;
		for (int k = 0; k < RomDepth; k++) begin
			r = $atan(real'(k) / 512.0) * real'(HalfTurn) / Pi;
			rom[k] = TabWidth'($rtoi(r + 0.5));
		end
		return rom;
	endfunction

	localparam rom_t AtanRom = atan_rom_build();

endpackage

FILE: hdl/atp_front.sv
// Front stages: magnitudes, ordering, octant code and divider operand set-up.
module atp_front (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [atp_pkg::SampleWidth-1:0] sample_i,
	input  logic signed [atp_pkg::SampleWidth-1:0] sample_q,
	output atp_pkg::div_word_t                 word
);
	import atp_pkg::*;

	logic                   neg_i_s1, neg_q_s1;
	logic [SampleWidth-1:0] mag_i_s1, mag_q_s1;
	logic                   swap;
	logic                   big;
	logic [SampleWidth-1:0] mx, mn;
	div_word_t              word_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_i_s1 <= sample_i[SampleWidth-1];
			neg_q_s1 <= sample_q[SampleWidth-1];
			mag_i_s1 <= sample_i[SampleWidth-1] ? (~sample_i + 1'b1) : sample_i;
			mag_q_s1 <= sample_q[SampleWidth-1] ? (~sample_q + 1'b1) : sample_q;
		end
	end

	always_comb begin
		swap = mag_i_s1 < mag_q_s1;
		big  = (mag_i_s1 > BigMax) || (mag_q_s1 > BigMax);
		mx   = swap ? mag_q_s1 : mag_i_s1;
		mn   = swap ? mag_i_s1 : mag_q_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s2.rem  <= big ? mn : {mn[SampleWidth-FracShift-1:0], FracShift'(0)};
			word_s2.dsh  <= big ? {mx[SampleWidth-1:FracShift], FracShift'(0)}
			                    : {mx[SampleWidth-FracShift-1:0], FracShift'(0)};
			word_s2.quot <= '0;
			word_s2.oct  <= octant_t'({neg_i_s1, neg_q_s1, swap});
			word_s2.zero <= (mag_i_s1 | mag_q_s1) == '0;
		end
	end

	assign word = word_s2;

endmodule

FILE: hdl/atp_div_cell.sv
// One restoring-division cell: settles one quotient bit and hands on the rest.
module atp_div_cell (
	input  logic               clk,
	input  logic               en,
	input  atp_pkg::div_word_t d,
	output atp_pkg::div_word_t q
);
	import atp_pkg::*;

	logic      ge;
	div_word_t q_q;

	assign ge = d.rem >= d.dsh;

	always_ff @(posedge clk) begin
		if (en) begin
			q_q.rem  <= ge ? (d.rem - d.dsh) : d.rem;
			q_q.dsh  <= d.dsh >> 1;
			q_q.quot <= {d.quot[QuotBits-2:0], ge};
			q_q.oct  <= d.oct;
			q_q.zero <= d.zero;
		end
	end

	assign q = q_q;

endmodule

FILE: hdl/atp_fold.sv
// Table lookup and octant folding into the full-circle phase.
module atp_fold (
	input  logic                              clk,
	input  logic                              en,
	input  atp_pkg::div_word_t                word,
	output logic [atp_pkg::PhaseWidth-1:0]    phase
);
	import atp_pkg::*;

	localparam logic [PhaseWidth-1:0] Ht = PhaseWidth'(HalfTurn);
	localparam logic [PhaseWidth-1:0] Qt = PhaseWidth'(QuarterTurn);

	logic [AddrWidth-1:0]  addr;
	logic [TabWidth-1:0]   t_s1;
	octant_t               oct_s1;
	logic [PhaseWidth-1:0] t12;
	logic [PhaseWidth-1:0] ph;
	logic [PhaseWidth-1:0] phase_s2;

	always_comb begin
		if (word.zero) begin
			addr = '0;
		end else if (word.quot[QuotBits-1]) begin
			addr = AddrMax;
		end else begin
			addr = word.quot[AddrWidth-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= AtanRom[addr];
			oct_s1 <= word.oct;
		end
	end

	always_comb begin
		t12 = {(PhaseWidth-TabWidth)'(0), t_s1};
		unique case (oct_s1)
			OctQ1Lo: ph = t12;
			OctQ1Hi: ph = Qt - t12;
			OctQ4Lo: ph = '0 - t12;
			OctQ4Hi: ph = t12 - Qt;
			OctQ2Lo: ph = Ht - t12;
			OctQ2Hi: ph = Qt + t12;
			OctQ3Lo: ph = t12 - Ht;
			OctQ3Hi: ph = '0 - Qt - t12;
			default: ph = t12;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s2 <= ph;
		end
	end

	assign phase = phase_s2;

endmodule

FILE: hdl/atan2_phase_lut.sv
// Top level: pipelined phase-angle extractor for complex samples.
// Takes one (I, Q) sample per clock while in_ready is high and returns its
// phase, with pi = 1608. The pipeline has two front stages (magnitudes,
// ordering), a chain of ten division cells that each settle one quotient bit,
// and two stages for the arctangent table lookup and octant folding. The whole
// pipeline advances together and holds while a finished result waits on
// out_ready; in_ready follows that condition.
module atan2_phase_lut (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [atp_pkg::SampleWidth-1:0] sample_i,
	input  logic signed [atp_pkg::SampleWidth-1:0] sample_q,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [atp_pkg::PhaseWidth-1:0]  phase
);
	import atp_pkg::*;

	logic                  en;
	logic [PipeDepth-1:0]  vld_q;
	div_word_t             chain [QuotBits+1];
	logic [PhaseWidth-1:0] phase_raw;

	assign en       = !vld_q[PipeDepth-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PipeDepth-2:0], in_valid};
		end
	end

	atp_front u_front (
		.clk      (clk),
		.en       (en),
		.sample_i (sample_i),
		.sample_q (sample_q),
		.word     (chain[0])
	);

	for (genvar g = 0; g < QuotBits; g++) begin : g_cell
		atp_div_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (chain[g]),
			.q   (chain[g+1])
		);
	end

	atp_fold u_fold (
		.clk   (clk),
		.en    (en),
		.word  (chain[QuotBits]),
		.phase (phase_raw)
	);

	assign out_valid = vld_q[PipeDepth-1];
	assign phase     = signed'(phase_raw);

endmodule
